>>> hdl/threshold_burst_gate_power_assert.svh
// Assertion macros for the burst gate checker.
`ifndef THRESHOLD_BURST_GATE_POWER_ASSERT_SVH
`define THRESHOLD_BURST_GATE_POWER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TBGP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define TBGP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tbgp_pkg.sv
`default_nettype none
package tbgp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int SUM_W     = 48;
    localparam int MEAN_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [COUNT_W-1:0] BACKOFF_RESET = COUNT_W'(20000);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_CNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF   = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_i;
        logic signed [SAMPLE_W-1:0] sample_q;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_i;
        logic signed [SAMPLE_W-1:0] out_q;
        logic                       burst_end;
        logic [MEAN_W-1:0]          mean_power;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_EMIT
    } tbgp_state_t;

    typedef struct packed {
        logic backoff_step;
        logic trigger;
        logic capture;
        logic mul;
        logic add;
        logic div_start;
        logic load_out;
    } tbgp_cmd_t;

    typedef struct packed {
        logic enable;
        logic in_backoff;
        logic armed;
        logic trig_hit;
        logic last;
        logic div_busy;
        logic out_busy;
    } tbgp_status_t;

endpackage
`default_nettype wire

>>> hdl/threshold_burst_gate_power.sv
// Burst gate with mean power for a stream of signed I/Q words.
// Input channel in_valid/in_stall/in_word carries one I/Q sample per word;
// output channel out_valid/out_stall/out_word carries passed samples, with
// burst_end and mean_power set on the last sample of each burst.
// Configuration: cfg_wr with cfg_index (0 enable, 1 threshold, 2 burst length,
// 3 backoff_len) and cfg_data, one write per cycle; the user must write
// only while idle, as the block itself does not enforce it. A dropped word
// (disabled, backoff, trigger search) is accepted and discarded while idle.
// A passed word goes through accept, square, accumulate and emit to the
// output register; the last word of a burst adds the serial divider, 48
// steps, before emit. One word is worked on at a time; in_stall is high from
// accept until the result is registered.
// Output register: the next word is accepted while a result waits; only a
// new result stalls behind a full, stalled output register.
// Reset: gate disarmed, no backoff, threshold 0, burst length 1,
// backoff_len 20000, block disabled, output empty.
`default_nettype none
module threshold_burst_gate_power
    import tbgp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_word_t             in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_word
);

    tbgp_cmd_t    cmd;
    tbgp_status_t status;

    tbgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tbgp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

>>> hdl/tbgp_ctrl.sv
`default_nettype none
module tbgp_ctrl
    import tbgp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire tbgp_status_t status,
    output tbgp_cmd_t         cmd
);

    tbgp_state_t state_reg;
    tbgp_state_t state_next;
    logic        accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.enable && !status.in_backoff && status.armed)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = status.last ? ST_DIV : ST_EMIT;
            ST_DIV:  state_next = status.div_busy ? ST_DIV : ST_EMIT;
            ST_EMIT: state_next = status.out_busy ? ST_EMIT : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.enable)
                begin
                    if (status.in_backoff)
                    begin
                        cmd.backoff_step = 1'b1;
                    end
                    else if (!status.armed)
                    begin
                        cmd.trigger = status.trig_hit;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                    end
                end
            end
            ST_MUL:  cmd.mul = 1'b1;
            ST_ADD:
            begin
                cmd.add       = 1'b1;
                cmd.div_start = status.last;
            end
            ST_DIV:  cmd = '0;
            ST_EMIT: cmd.load_out = !status.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/tbgp_div.sv
`default_nettype none
module tbgp_div
    import tbgp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output logic                    busy,
    output logic [SUM_W-1:0]        quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] rem_next;
    logic [SUM_W-1:0]   quot_reg;
    logic [SUM_W-1:0]   quot_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   diff;
    logic               ge;

    assign rem_sh = {rem_reg, quot_reg[SUM_W-1]};
    assign diff   = rem_sh - {1'b0, divisor};
    assign ge     = (rem_sh >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = CNT_W'(SUM_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            quot_next = {quot_reg[SUM_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

>>> hdl/tbgp_dp.sv
`default_nettype none
module tbgp_dp
    import tbgp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire in_word_t             in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_word,
    input  wire tbgp_cmd_t            cmd,
    output tbgp_status_t              status
);

    logic                       enable_reg;
    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic [COUNT_W-1:0]         burst_set_reg;
    logic [COUNT_W-1:0]         backoff_len_reg;

    logic                       armed_reg;
    logic                       armed_next;
    logic                       backoff_reg;
    logic                       backoff_next;
    logic [COUNT_W-1:0]         backoff_left_reg;
    logic [COUNT_W-1:0]         backoff_left_next;
    logic [COUNT_W-1:0]         burst_left_reg;
    logic [COUNT_W-1:0]         burst_left_next;
    logic [COUNT_W-1:0]         burst_total_reg;
    logic [COUNT_W-1:0]         burst_total_next;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [SUM_W-1:0]           sum_add;

    logic signed [SAMPLE_W-1:0] samp_i_reg;
    logic signed [SAMPLE_W-1:0] samp_q_reg;
    logic signed [PROD_W-1:0]   sqi_full;
    logic signed [PROD_W-1:0]   sqq_full;
    logic [PROD_W-1:0]          sqi_reg;
    logic [PROD_W-1:0]          sqq_reg;

    out_word_t                  out_word_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic                       last;
    logic                       div_busy;
    logic [SUM_W-1:0]           quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            threshold_reg   <= '0;
            burst_set_reg   <= COUNT_W'(1);
            backoff_len_reg <= BACKOFF_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_reg      <= cfg_data[0];
                CFG_THRESHOLD: threshold_reg   <= cfg_data[SAMPLE_W-1:0];
                CFG_BURST_CNT: burst_set_reg   <= cfg_data[COUNT_W-1:0];
                CFG_BACKOFF:   backoff_len_reg <= cfg_data[COUNT_W-1:0];
                default:       enable_reg      <= enable_reg;
            endcase
        end
    end

    assign last    = (burst_left_reg <= COUNT_W'(1));
    assign sum_add = sum_reg + SUM_W'(sqi_reg) + SUM_W'(sqq_reg);

    always_comb
    begin
        armed_next        = armed_reg;
        backoff_next      = backoff_reg;
        backoff_left_next = backoff_left_reg;
        burst_left_next   = burst_left_reg;
        burst_total_next  = burst_total_reg;
        sum_next          = sum_reg;
        if (cmd.backoff_step)
        begin
            if (backoff_left_reg <= COUNT_W'(1))
            begin
                backoff_left_next = '0;
                backoff_next      = 1'b0;
            end
            else
            begin
                backoff_left_next = backoff_left_reg - COUNT_W'(1);
            end
        end
        if (cmd.trigger)
        begin
            armed_next        = 1'b1;
            backoff_left_next = backoff_len_reg;
            burst_left_next   = burst_set_reg;
            burst_total_next  = (burst_set_reg == '0) ? COUNT_W'(1) : burst_set_reg;
            sum_next          = '0;
        end
        if (cmd.add)
        begin
            sum_next = sum_add;
        end
        if (cmd.load_out)
        begin
            if (last)
            begin
                armed_next      = 1'b0;
                backoff_next    = 1'b1;
                burst_left_next = burst_set_reg;
                sum_next        = '0;
            end
            else
            begin
                burst_left_next = burst_left_reg - COUNT_W'(1);
            end
        end
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            backoff_reg      <= 1'b0;
            backoff_left_reg <= '0;
            burst_left_reg   <= '0;
            burst_total_reg  <= COUNT_W'(1);
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            armed_reg        <= armed_next;
            backoff_reg      <= backoff_next;
            backoff_left_reg <= backoff_left_next;
            burst_left_reg   <= burst_left_next;
            burst_total_reg  <= burst_total_next;
            sum_reg          <= sum_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign sqi_full = samp_i_reg * samp_i_reg;
    assign sqq_full = samp_q_reg * samp_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            samp_i_reg <= in_word.sample_i;
            samp_q_reg <= in_word.sample_q;
        end
        if (cmd.mul)
        begin
            sqi_reg <= sqi_full;
            sqq_reg <= sqq_full;
        end
        if (cmd.load_out)
        begin
            out_word_reg.out_i      <= samp_i_reg;
            out_word_reg.out_q      <= samp_q_reg;
            out_word_reg.burst_end  <= last;
            out_word_reg.mean_power <= last ? quotient[MEAN_W-1:0] : '0;
        end
    end

    tbgp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_add),
        .divisor  (burst_total_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status.enable     = enable_reg;
    assign status.in_backoff = backoff_reg;
    assign status.armed      = armed_reg;
    assign status.trig_hit   = (in_word.sample_i > threshold_reg) &&
                               (in_word.sample_q > threshold_reg);
    assign status.last       = last;
    assign status.div_busy   = div_busy;
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
`default_nettype wire

>>> hdl/tbgp_checker.sv
`default_nettype none
`include "threshold_burst_gate_power_assert.svh"
module tbgp_checker
    import tbgp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    `TBGP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped")
    `TBGP_ASSERT_NXT(a_out_stable, out_valid && out_stall,
                     $stable(out_word), "output word changed")
    `TBGP_ASSERT_IMP(a_mean_zero, out_valid && !out_word.burst_end,
                     out_word.mean_power == '0, "mean set off burst end")
    `TBGP_ASSERT_IMP(a_emit_busy, $rose(out_valid),
                     $past(in_stall), "result without work in progress")

endmodule

bind threshold_burst_gate_power tbgp_checker u_tbgp_checker (.*);
`default_nettype wire
